[hw/rtl/cbru_pkg.sv]
`default_nettype none

package cbru_pkg;

    typedef enum logic [1:0] {
        KIND_HEADER    = 2'd0,
        KIND_SAMPLE    = 2'd1,
        KIND_SIZE_ERR  = 2'd2,
        KIND_COUNT_ERR = 2'd3
    } cbru_kind_t;

    // how one queued entry expands into result items
    typedef enum logic [1:0] {
        MODE_SINGLE  = 2'd0,
        MODE_HDR_ERR = 2'd1,
        MODE_PERM    = 2'd2
    } cbru_mode_t;

    localparam logic [3:0] FID_NONE      = 4'd0;
    localparam logic [3:0] FID_TIMESTAMP = 4'd0;
    localparam logic [3:0] FID_COUNT     = 4'd1;
    localparam logic [3:0] FID_NRX       = 4'd2;
    localparam logic [3:0] FID_NTX       = 4'd3;
    localparam logic [3:0] FID_RSSI_A    = 4'd4;
    localparam logic [3:0] FID_NOISE     = 4'd7;
    localparam logic [3:0] FID_AGC       = 4'd8;
    localparam logic [3:0] FID_PERM_0    = 4'd9;
    localparam logic [3:0] FID_RATE      = 4'd12;

    localparam logic [9:0] POS_TIMESTAMP_END = 10'd3;
    localparam logic [9:0] POS_COUNT_END     = 10'd5;
    localparam logic [9:0] POS_NRX           = 10'd8;
    localparam logic [9:0] POS_NTX           = 10'd9;
    localparam logic [9:0] POS_RSSI_A        = 10'd10;
    localparam logic [9:0] POS_RSSI_C        = 10'd12;
    localparam logic [9:0] POS_NOISE         = 10'd13;
    localparam logic [9:0] POS_AGC           = 10'd14;
    localparam logic [9:0] POS_ANT_SEL       = 10'd15;
    localparam logic [9:0] POS_LENGTH_END    = 10'd17;
    localparam logic [9:0] POS_RATE_END      = 10'd19;
    localparam logic [9:0] POS_PAYLOAD       = 10'd20;
    localparam logic [9:0] POS_MAX           = 10'd1023;

    localparam int MAX_TX           = 3;
    localparam int BIT_OFFSET_START = 3;
    localparam int SUB_STEP         = 3;
    localparam int ANT_STEP         = 16;
    localparam int QUEUE_DEPTH      = 4;

    typedef struct packed {
        cbru_kind_t        kind;
        logic [3:0]        field_id;
        logic [31:0]       field_value;
        logic [4:0]        subcarrier;
        logic [1:0]        antenna;
        logic signed [7:0] csi_real;
        logic signed [7:0] csi_imag;
        logic              last;
    } cbru_result_t;

    typedef struct packed {
        cbru_mode_t   mode;
        cbru_result_t res;
    } cbru_entry_t;

    // permutation sum that marks a valid map for a given antenna count
    function automatic logic [3:0] tri_sum(input logic [1:0] rx);
        logic [3:0] s;
        case (rx)
            2'd0:    s = 4'd0;
            2'd1:    s = 4'd1;
            2'd2:    s = 4'd3;
            default: s = 4'd6;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/cbru_front.sv]
`default_nettype none

module cbru_front #(
    parameter int SUBCARRIERS = 30,
    parameter int MAX_RX      = 3
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [7:0]         data_byte,
    input  wire logic               first_byte,
    input  wire logic               push,
    output logic                    full,
    output logic                    q_push,
    output cbru_pkg::cbru_entry_t   q_entry,
    input  wire logic               q_full
);
    import cbru_pkg::*;

    localparam int SUB_W  = $clog2(SUBCARRIERS + 1);
    localparam int BO_MAX = SUBCARRIERS * (SUB_STEP + ANT_STEP * MAX_RX) + BIT_OFFSET_START;
    localparam int BO_W   = $clog2(BO_MAX + 1);
    localparam int CMP_W  = (BO_W + 1 > 10) ? BO_W + 1 : 10;

    logic [9:0]       pos_reg, pos_next, pos;
    logic [23:0]      sh_reg, sh_next, sh, nsh;
    logic [1:0]       rx_reg, rx_next, rx;
    logic [1:0]       tx_reg, tx_next, tx;
    logic [1:0]       perm_reg [3];
    logic [1:0]       perm_next [3];
    logic [1:0]       perm [3];
    logic             use_reg, use_next, use_p;
    logic [BO_W-1:0]  bo_reg, bo_next, bo;
    logic [SUB_W-1:0] sub_reg, sub_next, sub, sub_inc;
    logic [1:0]       ant_reg, ant_next, ant, ant_inc;
    logic [15:0]      prior_reg, prior_next, prior;
    logic             dead_reg, dead_next;

    logic             accept, live, has_result;
    logic [15:0]      len_v;
    logic [9:0]       p;
    logic [BO_W:0]    bo15;
    logic [3:0]       rshift;
    logic [23:0]      pair;
    logic [3:0]       psum;
    logic [3:0]       rt;
    logic [15:0]      prod;
    logic [6:0]       sub_wide;
    logic [1:0]       slot;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign live   = first_byte || !dead_reg;

    // a first byte restarts the record from cleared state
    always_comb
    begin
        pos   = first_byte ? '0 : pos_reg;
        sh    = first_byte ? '0 : sh_reg;
        rx    = first_byte ? '0 : rx_reg;
        tx    = first_byte ? '0 : tx_reg;
        use_p = first_byte ? 1'b0 : use_reg;
        bo    = first_byte ? BO_W'(BIT_OFFSET_START) : bo_reg;
        sub   = first_byte ? '0 : sub_reg;
        ant   = first_byte ? '0 : ant_reg;
        prior = first_byte ? '0 : prior_reg;
        for (int i = 0; i < 3; i++)
        begin
            perm[i] = first_byte ? 2'd0 : perm_reg[i];
        end
    end

    assign nsh      = {data_byte, sh[23:8]};
    assign len_v    = {data_byte, sh[23:16]};
    assign p        = pos - POS_PAYLOAD;
    assign bo15     = {1'b0, bo} + (BO_W + 1)'(15);
    assign rshift   = {1'b0, bo15[2:0]} + 4'd1;
    assign pair     = nsh >> rshift;
    assign psum     = 4'd3 + {2'b00, data_byte[1:0]} + {2'b00, data_byte[3:2]}
                      + {2'b00, data_byte[5:4]};
    assign rt       = {2'b00, rx} * {2'b00, data_byte[1:0]};
    assign prod     = 16'(SUBCARRIERS) * {8'd0, rt, 4'b0011};
    assign sub_wide = 7'(sub);
    assign ant_inc  = ant + 2'd1;
    assign sub_inc  = sub + SUB_W'(1);

    always_comb
    begin
        case (ant)
            2'd0:    slot = use_p ? perm[0] : 2'd0;
            2'd1:    slot = use_p ? perm[1] : 2'd1;
            2'd2:    slot = use_p ? perm[2] : 2'd2;
            default: slot = 2'd3;
        endcase
    end

    always_comb
    begin
        pos_next   = pos_reg;
        sh_next    = sh_reg;
        rx_next    = rx_reg;
        tx_next    = tx_reg;
        use_next   = use_reg;
        bo_next    = bo_reg;
        sub_next   = sub_reg;
        ant_next   = ant_reg;
        prior_next = prior_reg;
        dead_next  = dead_reg;
        for (int i = 0; i < 3; i++)
        begin
            perm_next[i] = perm_reg[i];
        end

        has_result = 1'b0;
        q_entry    = '0;
        q_entry.mode      = MODE_SINGLE;
        q_entry.res.kind  = KIND_HEADER;

        if (accept && live)
        begin
            pos_next   = (pos < POS_MAX) ? pos + 10'd1 : pos;
            sh_next    = nsh;
            rx_next    = rx;
            tx_next    = tx;
            use_next   = use_p;
            bo_next    = bo;
            sub_next   = sub;
            ant_next   = ant;
            prior_next = prior;
            dead_next  = 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                perm_next[i] = perm[i];
            end

            unique case (pos) inside
                POS_TIMESTAMP_END:
                begin
                    has_result = 1'b1;
                    q_entry.res.field_id    = FID_TIMESTAMP;
                    q_entry.res.field_value = {data_byte, sh};
                end
                POS_COUNT_END:
                begin
                    has_result = 1'b1;
                    q_entry.res.field_id    = FID_COUNT;
                    q_entry.res.field_value = {16'd0, len_v};
                end
                POS_NRX:
                begin
                    has_result = 1'b1;
                    q_entry.res.field_id    = FID_NRX;
                    q_entry.res.field_value = {24'd0, data_byte};
                    if (data_byte == 8'd0 || data_byte > 8'(MAX_RX))
                    begin
                        q_entry.mode = MODE_HDR_ERR;
                        dead_next    = 1'b1;
                    end
                    else
                    begin
                        rx_next = data_byte[1:0];
                    end
                end
                POS_NTX:
                begin
                    has_result = 1'b1;
                    q_entry.res.field_id    = FID_NTX;
                    q_entry.res.field_value = {24'd0, data_byte};
                    if (data_byte == 8'd0 || data_byte > 8'(MAX_TX))
                    begin
                        q_entry.mode = MODE_HDR_ERR;
                        dead_next    = 1'b1;
                    end
                    else
                    begin
                        tx_next    = data_byte[1:0];
                        prior_next = 16'((prod + 16'd7) >> 3);
                    end
                end
                [POS_RSSI_A:POS_RSSI_C]:
                begin
                    has_result = 1'b1;
                    q_entry.res.field_id    = FID_RSSI_A + 4'(pos - POS_RSSI_A);
                    q_entry.res.field_value = {24'd0, data_byte};
                end
                POS_NOISE:
                begin
                    has_result = 1'b1;
                    q_entry.res.field_id    = FID_NOISE;
                    q_entry.res.field_value = {24'd0, data_byte};
                end
                POS_AGC:
                begin
                    has_result = 1'b1;
                    q_entry.res.field_id    = FID_AGC;
                    q_entry.res.field_value = {24'd0, data_byte};
                end
                POS_ANT_SEL:
                begin
                    has_result = 1'b1;
                    q_entry.mode            = MODE_PERM;
                    q_entry.res.field_id    = FID_PERM_0;
                    q_entry.res.field_value = {24'd0, data_byte};
                    for (int i = 0; i < 3; i++)
                    begin
                        perm_next[i] = data_byte[2*i +: 2];
                    end
                    use_next = (psum == tri_sum(rx));
                end
                POS_LENGTH_END:
                begin
                    if (len_v != prior)
                    begin
                        has_result = 1'b1;
                        q_entry.res.kind        = KIND_SIZE_ERR;
                        q_entry.res.field_value = {16'd0, len_v};
                        q_entry.res.last        = 1'b1;
                        dead_next               = 1'b1;
                    end
                end
                POS_RATE_END:
                begin
                    has_result = 1'b1;
                    q_entry.res.field_id    = FID_RATE;
                    q_entry.res.field_value = {16'd0, len_v};
                end
                default:
                begin
                end
            endcase

            // payload: one sample can complete per byte at most
            if (pos >= POS_PAYLOAD && CMP_W'(bo15[BO_W:3]) == CMP_W'(p) && p >= 10'd2)
            begin
                has_result = 1'b1;
                q_entry.res.kind       = KIND_SAMPLE;
                q_entry.res.subcarrier = sub_wide[4:0];
                q_entry.res.antenna    = slot;
                q_entry.res.csi_real   = pair[7:0];
                q_entry.res.csi_imag   = pair[15:8];
                bo_next  = bo + BO_W'(ANT_STEP);
                ant_next = ant_inc;
                if (ant_inc >= rx)
                begin
                    ant_next = 2'd0;
                    sub_next = sub_inc;
                    bo_next  = bo + BO_W'(ANT_STEP + SUB_STEP);
                    if (sub_inc >= SUB_W'(SUBCARRIERS))
                    begin
                        q_entry.res.last = 1'b1;
                        dead_next        = 1'b1;
                    end
                end
            end
        end
    end

    assign q_push = accept && live && has_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            sh_reg    <= '0;
            rx_reg    <= '0;
            tx_reg    <= '0;
            use_reg   <= 1'b0;
            bo_reg    <= BO_W'(BIT_OFFSET_START);
            sub_reg   <= '0;
            ant_reg   <= '0;
            prior_reg <= '0;
            dead_reg  <= 1'b1;
            for (int i = 0; i < 3; i++)
            begin
                perm_reg[i] <= 2'd0;
            end
        end
        else
        begin
            pos_reg   <= pos_next;
            sh_reg    <= sh_next;
            rx_reg    <= rx_next;
            tx_reg    <= tx_next;
            use_reg   <= use_next;
            bo_reg    <= bo_next;
            sub_reg   <= sub_next;
            ant_reg   <= ant_next;
            prior_reg <= prior_next;
            dead_reg  <= dead_next;
            for (int i = 0; i < 3; i++)
            begin
                perm_reg[i] <= perm_next[i];
            end
        end
    end

`ifndef SYNTH
    a_first_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && first_byte) |=> pos_reg == 10'd1)
        else $error("first byte did not restart byte position");
    a_sub_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg <= SUB_W'(SUBCARRIERS))
        else $error("subcarrier index ran past the last subcarrier");
    a_last_kills: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && q_entry.res.last) |=> dead_reg)
        else $error("record still live after its last item");
`endif

endmodule

`default_nettype wire

[hw/rtl/cbru_queue.sv]
`default_nettype none

module cbru_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  cbru_pkg::cbru_entry_t      wr_data,
    output logic                       full,
    input  wire logic                  rd_en,
    output logic                       rd_valid,
    output cbru_pkg::cbru_entry_t      rd_data
);
    import cbru_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cbru_entry_t      slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slots_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");
    a_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count missed a write");
    a_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        (do_rd && !do_wr) |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("queue count missed a read");
`endif

endmodule

`default_nettype wire

[hw/rtl/cbru_back.sv]
`default_nettype none

module cbru_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  head_valid,
    input  cbru_pkg::cbru_entry_t      head,
    output logic                       head_pop,
    input  wire logic                  pop,
    output logic                       empty,
    output cbru_pkg::cbru_result_t     result
);
    import cbru_pkg::*;

    cbru_result_t out_reg, gen;
    logic         out_valid_reg, out_valid_next;
    logic [1:0]   idx_reg, idx_next;
    logic [1:0]   last_idx;
    logic [31:0]  sel_bits;
    logic         load;

    assign empty  = !out_valid_reg;
    assign result = out_reg;
    assign load   = head_valid && (!out_valid_reg || pop);
    assign sel_bits = head.res.field_value >> {idx_reg, 1'b0};

    always_comb
    begin
        gen = head.res;
        case (head.mode)
            MODE_HDR_ERR:
            begin
                last_idx = 2'd1;
                if (idx_reg != 2'd0)
                begin
                    gen.kind     = KIND_COUNT_ERR;
                    gen.field_id = FID_NONE;
                    gen.last     = 1'b1;
                end
            end
            MODE_PERM:
            begin
                // entries are stored as perm minus one
                last_idx         = 2'd2;
                gen.field_id     = FID_PERM_0 + {2'b00, idx_reg};
                gen.field_value  = {29'd0, {1'b0, sel_bits[1:0]} + 3'd1};
            end
            default:
            begin
                last_idx = 2'd0;
            end
        endcase
    end

    assign head_pop = load && (idx_reg == last_idx);

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = (idx_reg == last_idx) ? 2'd0 : idx_reg + 2'd1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= gen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

`ifndef SYNTH
    a_idx_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 2'd0 |-> head_valid)
        else $error("expansion in progress with no queued entry");
    a_idx_mode: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 2'd0 |-> head.mode != MODE_SINGLE)
        else $error("single entry expanded past its one item");
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= 2'd2)
        else $error("expansion index out of range");
`endif

endmodule

`default_nettype wire

[hw/rtl/csi_bfee_record_unpacker.sv]
// channel   handshake      payload
// input     push / full    data_byte[7:0], first_byte
// result    pop / empty    kind, field_id, field_value, subcarrier, antenna,
//                          csi_real, csi_imag, last
//
// one byte is taken per cycle while full is low; the front classifies it and queues at most one entry,
// the back expands entries into result items, one per cycle while pop is held, from a 4-entry queue.
// a byte yields up to three items (antenna select gives three, a bad antenna
// count two); the bytes right after these yield none, so with pop high full stays low.
// a result passes through the queue and then the output register before it can be popped;
// holding pop low fills the output register and the queue, and then full stalls the input.
// after reset bytes are ignored until one arrives with first_byte set.
`default_nettype none

module csi_bfee_record_unpacker #(
    parameter int SUBCARRIERS = 30,
    parameter int MAX_RX      = 3
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [7:0]         data_byte,
    input  wire logic               first_byte,
    input  wire logic               push,
    output logic                    full,
    output logic [1:0]              kind,
    output logic [3:0]              field_id,
    output logic [31:0]             field_value,
    output logic [4:0]              subcarrier,
    output logic [1:0]              antenna,
    output logic signed [7:0]       csi_real,
    output logic signed [7:0]       csi_imag,
    output logic                    last,
    output logic                    empty,
    input  wire logic               pop
);
    import cbru_pkg::*;

    logic         q_push, q_full, head_valid, head_pop;
    cbru_entry_t  q_entry, head;
    cbru_result_t res;

    cbru_front #(
        .SUBCARRIERS (SUBCARRIERS),
        .MAX_RX      (MAX_RX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .push       (push),
        .full       (full),
        .q_push     (q_push),
        .q_entry    (q_entry),
        .q_full     (q_full)
    );

    cbru_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_data  (q_entry),
        .full     (q_full),
        .rd_en    (head_pop),
        .rd_valid (head_valid),
        .rd_data  (head)
    );

    cbru_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .pop        (pop),
        .empty      (empty),
        .result     (res)
    );

    assign kind        = res.kind;
    assign field_id    = res.field_id;
    assign field_value = res.field_value;
    assign subcarrier  = res.subcarrier;
    assign antenna     = res.antenna;
    assign csi_real    = res.csi_real;
    assign csi_imag    = res.csi_imag;
    assign last        = res.last;

endmodule

`default_nettype wire
